// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/wdst_pkg.sv =====
// ---------------------------------------------------------------------------
// wdst_pkg
// types and codes shared by the weave delta stack tracker files
// ---------------------------------------------------------------------------
package wdst_pkg;

  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    FUNC_INS_BEGIN = 2'd0,
    FUNC_DEL_BEGIN = 2'd1,
    FUNC_END       = 2'd2,
    FUNC_TEXT      = 2'd3
  } func_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NOT_FOUND = 2'd1,
    ERR_FULL      = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPL
  } state_t;

  typedef struct packed {
    logic  push;
    logic  remove;
    kind_t new_kind;
    kind_t repl_kind;
  } cell_ctrl_t;

endpackage

// ===== rtl/wdst_cell.sv =====
// ---------------------------------------------------------------------------
// wdst_cell
// one stack entry: holds a delta and its kind, compares against the key and
// takes the entry above when an entry at or below it is removed
// ---------------------------------------------------------------------------
module wdst_cell
  import wdst_pkg::*;
#(
  parameter int DELTA_BITS = 16,
  parameter int CNT_W      = 6,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DELTA_BITS-1:0] key,
  input  logic [DELTA_BITS-1:0] up_delta,
  input  kind_t                 up_kind,
  input  logic                  hit_in,
  input  logic                  sel_kind_in,
  input  logic                  rep_found_in,
  input  logic [DELTA_BITS-1:0] rep_delta_in,
  output logic [DELTA_BITS-1:0] delta,
  output kind_t                 kind,
  output logic                  hit_out,
  output logic                  sel_kind_out,
  output logic                  rep_found_out,
  output logic [DELTA_BITS-1:0] rep_delta_out
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [DELTA_BITS-1:0] delta_r;
  kind_t                 kind_r;
  logic                  occupied;
  logic                  match;
  logic                  cand;

  assign occupied = IDX_C < count;
  assign match    = occupied && (delta_r == key);
  assign cand     = occupied && (kind_r == ctrl.repl_kind);

  assign hit_out       = hit_in | match;
  assign sel_kind_out  = sel_kind_in | (match & !hit_in & (kind_r == KIND_DELETE));
  assign rep_found_out = rep_found_in | cand;
  assign rep_delta_out = rep_found_in ? rep_delta_in : (cand ? delta_r : '0);

  assign delta = delta_r;
  assign kind  = kind_r;

  // no match above this cell: it is the removed entry or lies above it
  always_ff @(posedge clk) begin
    if (ctrl.push && (count == IDX_C)) begin
      delta_r <= key;
      kind_r  <= ctrl.new_kind;
    end else if (ctrl.remove && !hit_in) begin
      delta_r <= up_delta;
      kind_r  <= up_kind;
    end
  end

endmodule

// ===== rtl/weave_delta_stack_tracker.sv =====
// ---------------------------------------------------------------------------
// weave_delta_stack_tracker
// follows weave body records and reports the active insert and delete deltas
// ---------------------------------------------------------------------------
// in channel: one record per item, in_tuser = record kind, in_tdata = delta.
// out channel: at most one result item per record, registered; text lines
//   give their active deltas, or nothing while existing_only is set and a
//   delete is active; a push onto a full stack or an end record whose delta
//   is not on the stack gives an error item with all data zero.
// cfg channel: one bit, existing_only; the user writes it only while the
//   block is idle, and the block itself does not enforce this.
// timing: a record is taken in S_IDLE and worked in S_EXEC; a matched end
//   record also passes through S_REPL, the second pass along the cell chain
//   that finds the topmost remaining entry of the removed kind.
// the stack is a row of cells; match, shift and replacement each run along the chain.
// out holds its item until taken; the next record is still accepted and
//   waits in the work cycle only if it has a result and the register is full.
// reset empties the stack, clears the active deltas and existing_only.
// ---------------------------------------------------------------------------
module weave_delta_stack_tracker
  import wdst_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int DELTA_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // delta_number
  input  logic [IN_USER_W-1:0]  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // has_insert, insert_delta, has_delete,
                                            // delete_delta, zero fill
  output logic [OUT_USER_W-1:0] out_tuser,  // error_code
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data    // existing_only
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(STACK_DEPTH);
  localparam int PAD_W = OUT_DATA_W - 2 * FIELD_W - 2;

  state_t                state_r, state_nxt;
  func_t                 func_r;
  logic [DELTA_BITS-1:0] key_r;
  kind_t                 kind_r;
  logic [CNT_W-1:0]      count_r;
  logic                  ins_valid_r, del_valid_r;
  logic [DELTA_BITS-1:0] ins_val_r, del_val_r;
  logic                  eo_r;
  logic                  out_valid_r;
  err_t                  out_err_r;
  logic                  out_hi_r, out_hd_r;
  logic [FIELD_W-1:0]    out_iv_r, out_dv_r;

  cell_ctrl_t            ctrl;
  logic                  emit;
  err_t                  emit_err;
  logic                  done;
  logic                  out_free;
  logic                  in_acc;

  logic [DELTA_BITS-1:0] d_c  [STACK_DEPTH:0];
  kind_t                 k_c  [STACK_DEPTH:0];
  logic                  hit_c [STACK_DEPTH:0];
  logic                  sk_c  [STACK_DEPTH:0];
  logic                  rf_c  [STACK_DEPTH:0];
  logic [DELTA_BITS-1:0] rd_c [STACK_DEPTH:0];

  assign d_c[STACK_DEPTH]   = '0;
  assign k_c[STACK_DEPTH]   = KIND_INSERT;
  assign hit_c[STACK_DEPTH] = 1'b0;
  assign sk_c[STACK_DEPTH]  = 1'b0;
  assign rf_c[STACK_DEPTH]  = 1'b0;
  assign rd_c[STACK_DEPTH]  = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    wdst_cell #(
      .DELTA_BITS (DELTA_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .count         (count_r),
      .key           (key_r),
      .up_delta      (d_c[i+1]),
      .up_kind       (k_c[i+1]),
      .hit_in        (hit_c[i+1]),
      .sel_kind_in   (sk_c[i+1]),
      .rep_found_in  (rf_c[i+1]),
      .rep_delta_in  (rd_c[i+1]),
      .delta         (d_c[i]),
      .kind          (k_c[i]),
      .hit_out       (hit_c[i]),
      .sel_kind_out  (sk_c[i]),
      .rep_found_out (rf_c[i]),
      .rep_delta_out (rd_c[i])
    );
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // control outputs
  always_comb begin
    in_tready      = 1'b0;
    ctrl.push      = 1'b0;
    ctrl.remove    = 1'b0;
    ctrl.new_kind  = (func_r == FUNC_DEL_BEGIN) ? KIND_DELETE : KIND_INSERT;
    ctrl.repl_kind = kind_r;
    emit           = 1'b0;
    emit_err       = ERR_OK;
    done           = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        case (func_r)
          FUNC_INS_BEGIN, FUNC_DEL_BEGIN: begin
            if (count_r == FULL_C) begin
              emit     = out_free;
              emit_err = ERR_FULL;
              done     = out_free;
            end else begin
              ctrl.push = 1'b1;
              done      = 1'b1;
            end
          end
          FUNC_END: begin
            if (!hit_c[0]) begin
              emit     = out_free;
              emit_err = ERR_NOT_FOUND;
              done     = out_free;
            end else begin
              ctrl.remove = 1'b1;
            end
          end
          FUNC_TEXT: begin
            if (eo_r && del_valid_r) begin
              done = 1'b1;
            end else begin
              emit = out_free;
              done = out_free;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_REPL: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (done) state_nxt = S_IDLE;
        else if (ctrl.remove) state_nxt = S_REPL;
      end
      S_REPL: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ins_valid_r <= 1'b0;
      del_valid_r <= 1'b0;
      eo_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) eo_r <= cfg_data;
      if (ctrl.push) begin
        count_r <= count_r + CNT_W'(1);
        if (ctrl.new_kind == KIND_DELETE) del_valid_r <= 1'b1;
        else ins_valid_r <= 1'b1;
      end else if (ctrl.remove) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (state_r == S_REPL) begin
        if (kind_r == KIND_DELETE) del_valid_r <= rf_c[0];
        else ins_valid_r <= rf_c[0];
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= func_t'(in_tuser);
      key_r  <= DELTA_BITS'(in_tdata);
    end
    if (ctrl.push) begin
      if (ctrl.new_kind == KIND_DELETE) del_val_r <= key_r;
      else ins_val_r <= key_r;
    end
    if (ctrl.remove) kind_r <= sk_c[0] ? KIND_DELETE : KIND_INSERT;
    if (state_r == S_REPL) begin
      if (kind_r == KIND_DELETE) del_val_r <= rd_c[0];
      else ins_val_r <= rd_c[0];
    end
    if (emit) begin
      out_err_r <= emit_err;
      if (emit_err == ERR_OK) begin
        out_hi_r <= ins_valid_r;
        out_hd_r <= del_valid_r;
        out_iv_r <= ins_valid_r ? FIELD_W'(ins_val_r) : '0;
        out_dv_r <= del_valid_r ? FIELD_W'(del_val_r) : '0;
      end else begin
        out_hi_r <= 1'b0;
        out_hd_r <= 1'b0;
        out_iv_r <= '0;
        out_dv_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_dv_r, out_hd_r, out_iv_r, out_hi_r};

endmodule

// ===== rtl/wdst_checker.sv =====
// ---------------------------------------------------------------------------
// wdst_checker
// port-level checks on the weave delta stack tracker
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wdst_checker
  import wdst_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  logic ins_clean;
  logic del_clean;

  // an inactive delta reads as zero
  assign ins_clean = out_tdata[0] || (out_tdata[16:1] == '0);
  assign del_clean = out_tdata[17] || (out_tdata[33:18] == '0);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMPLY(a_err_clean, clk, rst_n, out_tvalid && (out_tuser != ERR_OK), out_tdata == '0)
  `ASSERT_IMPLY(a_inactive_zero, clk, rst_n, out_tvalid, ins_clean && del_clean)
  `ASSERT_NEXT(a_in_gap, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_tvalid)

endmodule

bind weave_delta_stack_tracker wdst_checker u_wdst_checker (.*);

// ===== tb/sv/wdst_annot_checker.sv =====
// ---------------------------------------------------------------------------
// wdst_annot_checker
// watches the record, result and register channels of the weave delta stack
// tracker, keeps its own copy of the delta stack and the active deltas, and
// compares every result item field by field with the oldest expected
// annotation
// ---------------------------------------------------------------------------
module wdst_annot_checker
  import wdst_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // delta_number
  input  logic [IN_USER_W-1:0]  in_tuser,   // func
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // has_insert, insert_delta, has_delete,
                                            // delete_delta, zero fill
  input  logic [OUT_USER_W-1:0] out_tuser,  // error_code
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_data,   // existing_only
  output int                    fails,
  output int                    pending,
  output int                    n_records,
  output int                    n_lines,
  output int                    n_not_found,
  output int                    n_full
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    err_t               err;
    logic               has_ins;
    logic [FIELD_W-1:0] ins;
    logic               has_del;
    logic [FIELD_W-1:0] del;
  } annot_t;

  annot_t             annot_q[$];
  logic [FIELD_W-1:0] stk_delta[STACK_DEPTH];
  kind_t              stk_kind[STACK_DEPTH];
  int                 stk_count;
  logic               ins_on;
  logic [FIELD_W-1:0] ins_val;
  logic               del_on;
  logic [FIELD_W-1:0] del_val;
  logic               excl;

  task automatic track_record(input logic [1:0] f, input logic [FIELD_W-1:0] d);
    annot_t             a;
    kind_t              k;
    int                 pos;
    bit                 hit;
    logic [FIELD_W-1:0] repl;
    a.err     = ERR_OK;
    a.has_ins = 1'b0;
    a.ins     = '0;
    a.has_del = 1'b0;
    a.del     = '0;
    pos       = 0;
    hit       = 1'b0;
    repl      = '0;
    if (f == FUNC_INS_BEGIN || f == FUNC_DEL_BEGIN) begin
      if (stk_count >= STACK_DEPTH) begin
        a.err = ERR_FULL;
        annot_q.push_back(a);
        n_full++;
      end else begin
        k = (f == FUNC_INS_BEGIN) ? KIND_INSERT : KIND_DELETE;
        stk_delta[stk_count] = d;
        stk_kind[stk_count]  = k;
        stk_count++;
        if (k == KIND_INSERT) begin
          ins_on  = 1'b1;
          ins_val = d;
        end else begin
          del_on  = 1'b1;
          del_val = d;
        end
      end
    end else if (f == FUNC_END) begin
      for (int i = stk_count - 1; i >= 0; i--) begin
        if (!hit && stk_delta[i] == d) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (!hit) begin
        a.err = ERR_NOT_FOUND;
        annot_q.push_back(a);
        n_not_found++;
      end else begin
        k = stk_kind[pos];
        for (int i = pos; i < stk_count - 1; i++) begin
          stk_delta[i] = stk_delta[i+1];
          stk_kind[i]  = stk_kind[i+1];
        end
        stk_count--;
        hit = 1'b0;
        for (int i = stk_count - 1; i >= 0; i--) begin
          if (!hit && stk_kind[i] == k) begin
            hit  = 1'b1;
            repl = stk_delta[i];
          end
        end
        if (k == KIND_INSERT) begin
          ins_on  = hit;
          ins_val = repl;
        end else begin
          del_on  = hit;
          del_val = repl;
        end
      end
    end else if (!(excl && del_on)) begin
      a.has_ins = ins_on;
      a.ins     = ins_on ? ins_val : '0;
      a.has_del = del_on;
      a.del     = del_on ? del_val : '0;
      annot_q.push_back(a);
      n_lines++;
    end
  endtask

  annot_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      annot_q.delete();
      stk_count   = 0;
      ins_on      = 1'b0;
      ins_val     = '0;
      del_on      = 1'b0;
      del_val     = '0;
      excl        = 1'b0;
      fails       = 0;
      n_records   = 0;
      n_lines     = 0;
      n_not_found = 0;
      n_full      = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (annot_q.size() == 0) begin
          $error("result item with no record waiting for one");
          fails++;
        end else begin
          want = annot_q.pop_front();
          if (out_tuser !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, out_tuser);
            fails++;
          end
          if (out_tdata[0] !== want.has_ins) begin
            $error("has_insert: expected %0d, got %0d", want.has_ins, out_tdata[0]);
            fails++;
          end
          if (out_tdata[16:1] !== want.ins) begin
            $error("insert_delta: expected %h, got %h", want.ins, out_tdata[16:1]);
            fails++;
          end
          if (out_tdata[17] !== want.has_del) begin
            $error("has_delete: expected %0d, got %0d", want.has_del, out_tdata[17]);
            fails++;
          end
          if (out_tdata[33:18] !== want.del) begin
            $error("delete_delta: expected %h, got %h", want.del, out_tdata[33:18]);
            fails++;
          end
          if (out_tdata[OUT_DATA_W-1:34] !== '0) begin
            $error("zero fill: expected 0, got %h", out_tdata[OUT_DATA_W-1:34]);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        excl = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        n_records++;
        track_record(in_tuser, in_tdata);
      end
    end
    pending = annot_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// regression for the weave delta stack tracker: directed records over the
// field extremes and stack corner cases, then random weave bodies made of
// nested insert and delete blocks with text lines, floods that fill the
// stack, and stray records, under three idle patterns and both settings of
// existing_only; the checker predicts and compares every result item
// ---------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import wdst_pkg::*;

  localparam int DEPTH = 32;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // delta_number
  logic [IN_USER_W-1:0]  in_tuser   = '0;   // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // has_insert, insert_delta, has_delete,
                                            // delete_delta, zero fill
  logic [OUT_USER_W-1:0] out_tuser;         // error_code
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data   = 1'b0; // existing_only

  int fails;
  int pending;
  int n_records;
  int n_lines;
  int n_not_found;
  int n_full;

  int send_idle  = 0;
  int recv_stall = 0;
  int sent       = 0;
  int n_cfg      = 0;

  logic [FIELD_W-1:0] open_deltas[$];

  weave_delta_stack_tracker #(
    .STACK_DEPTH(DEPTH),
    .DELTA_BITS (FIELD_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  wdst_annot_checker #(
    .STACK_DEPTH(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending),
    .n_records  (n_records),
    .n_lines    (n_lines),
    .n_not_found(n_not_found),
    .n_full     (n_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= (recv_stall == 0) || ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin
        send_idle  = 36;
        recv_stall = 59;
      end
      1: begin
        send_idle  = 59;
        recv_stall = 36;
      end
      default: begin
        send_idle  = 0;
        recv_stall = 0;
      end
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send(input func_t f, input logic [FIELD_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
    // shadow of the open deltas, used only to shape the stimulus
    if (f == FUNC_INS_BEGIN || f == FUNC_DEL_BEGIN) begin
      if (open_deltas.size() < DEPTH) open_deltas.push_back(d);
    end else if (f == FUNC_END) begin
      for (int i = open_deltas.size() - 1; i >= 0; i--) begin
        if (open_deltas[i] == d) begin
          open_deltas.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [FIELD_W-1:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return FIELD_W'($urandom_range(0, 7));
      1:       return 16'hFFFF - FIELD_W'($urandom_range(0, 3));
      default: return FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic func_t pick_begin();
    return $urandom_range(0, 1) ? FUNC_DEL_BEGIN : FUNC_INS_BEGIN;
  endfunction

  task automatic flood_stack();
    while (open_deltas.size() < DEPTH) begin
      send(pick_begin(), pick_delta());
      if ($urandom_range(0, 7) == 0) send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
    end
    send(FUNC_INS_BEGIN, FIELD_W'($urandom_range(0, 65535)));
    send(FUNC_DEL_BEGIN, FIELD_W'($urandom_range(0, 65535)));
    send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
    while (open_deltas.size() > 0) begin
      send(FUNC_END, open_deltas[$urandom_range(0, open_deltas.size() - 1)]);
      if ($urandom_range(0, 3) == 0) send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic run_phase(input int n_items, input bit flood);
    int target;
    int r;
    int idx;
    target = sent + n_items;
    if (flood) flood_stack();
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70 && (open_deltas.size() == 0 || (r < 40 && open_deltas.size() < 12))) begin
        send(pick_begin(), pick_delta());
        repeat ($urandom_range(0, 3)) send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
      end else if (r < 70) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, open_deltas.size() - 1)
                                          : open_deltas.size() - 1;
        send(FUNC_END, open_deltas[idx]);
        repeat ($urandom_range(0, 2)) send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) send(FUNC_TEXT, FIELD_W'($urandom_range(0, 65535)));
      end else begin
        send(func_t'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_mode(0);

    // all lines shown, empty stack first
    cfg_write(1'b0);
    send(FUNC_TEXT, 16'hFFFF);
    send(FUNC_END, 16'h0000);
    send(FUNC_INS_BEGIN, 16'h0001);
    send(FUNC_TEXT, 16'h0000);
    send(FUNC_DEL_BEGIN, 16'hFFFF);
    send(FUNC_TEXT, 16'hAAAA);
    send(FUNC_INS_BEGIN, 16'h0000);
    send(FUNC_TEXT, 16'h5555);
    // end of a buried insert leaves the top one active
    send(FUNC_END, 16'h0001);
    send(FUNC_TEXT, 16'h0000);
    // duplicate delta, topmost copy goes first
    send(FUNC_INS_BEGIN, 16'h0000);
    send(FUNC_END, 16'h0000);
    send(FUNC_TEXT, 16'hFFFF);
    send(FUNC_END, 16'hFFFF);
    send(FUNC_END, 16'h0000);
    send(FUNC_TEXT, 16'h0000);

    // existing-only: deleted lines vanish
    cfg_write(1'b1);
    send(FUNC_DEL_BEGIN, 16'h8000);
    send(FUNC_TEXT, 16'h0000);
    send(FUNC_INS_BEGIN, 16'h7FFF);
    send(FUNC_TEXT, 16'hFFFF);
    send(FUNC_END, 16'h8000);
    send(FUNC_TEXT, 16'h0000);
    send(FUNC_END, 16'h7FFF);

    for (int p = 0; p < 6; p++) begin
      cfg_write(p[0]);
      set_mode(p / 2);
      run_phase(108, p == 0 || p == 3);
    end

    settle();
    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("covered %0d records: %0d annotated lines, %0d ends with no open delta, %0d pushes onto a full stack",
             n_records, n_lines, n_not_found, n_full);
    $display("existing_only written %0d times across three idle patterns", n_cfg);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
